// ===== rtl/btc_pkg.sv =====
package btc_pkg;

  // Storage geometry
  localparam int MAX_BLOCK = 8;
  localparam int ST_AW     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int KEY_N     = 8;                 // entries in the key table
  localparam int KEY_W     = 3;                 // bits per key entry
  localparam int LEN_CAP   = (MAX_BLOCK < KEY_N) ? MAX_BLOCK : KEY_N;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int TABLE_W   = KEY_N * KEY_W;
  localparam int CFG_W     = TABLE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_TABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCATTER_MODE = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]   RST_BLOCK_LEN  = 4'd6;
  localparam logic [TABLE_W-1:0] RST_PERM_TABLE = 24'd16430113;

  typedef logic [ST_AW-1:0] st_addr_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } seq_state_t;

  // Key lookup result for one output position
  typedef struct packed {
    st_addr_t addr;   // store entry to read
    logic     pad;    // position holds a space
  } lookup_t;

  // Block length clamped to 1..LEN_CAP
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = len;
    if (len == '0) r = LEN_W'(1);
    else if (len > LEN_W'(LEN_CAP)) r = LEN_W'(LEN_CAP);
    return r;
  endfunction

  function automatic key_t key_at(input logic [TABLE_W-1:0] tbl,
                                  input key_t j);
    return tbl[j*KEY_W +: KEY_W];
  endfunction

endpackage

// ===== rtl/block_transposition_cipher_core.sv =====
// Block transposition cipher. Text words enter one byte at a time and are
// written into an 8-entry byte store. When block_len words are held, or a word
// with text_end arrives, the block is read back permuted by perm_table and
// emitted as block_len words, the last one flagged with block_end; positions
// not covered by text are spaces (0x20). Gather mode (scatter_mode = 0):
// output j is stored byte key[j]. Scatter mode: stored byte j lands at output
// key[j], the higher j winning on collisions. Key entries are zero-based; a
// key entry at or beyond the block length gives a space (gather) or is
// dropped (scatter). A block_len of 0 acts as 1, above 8 as 8. An input
// word is taken while the core is idle; each block word is read from the
// store, then loaded into the output register, which waits while a held
// output word is stalled. Input is stalled while a block is being emitted.
// Configuration may be written only while idle.
module block_transposition_cipher_core (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_wr_en,
  input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_W-1:0]      cfg_wr_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [btc_pkg::BYTE_W-1:0]     in_text_byte,
  input  logic                           in_text_end,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [btc_pkg::BYTE_W-1:0]     out_out_byte,
  output logic                           out_block_end
);
  import btc_pkg::*;

  // config registers
  logic [LEN_W-1:0]   block_len_r;
  logic [TABLE_W-1:0] perm_table_r;
  logic               scatter_mode_r;

  // sequencer
  seq_state_t         state_r, state_nxt;
  logic [LEN_W-1:0]   fill_r, fill_nxt;   // words held; also the valid limit
  key_t               pos_r, pos_nxt;     // output position being read
  logic               pad_r, pad_nxt;
  logic               last_r, last_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_end_r, out_end_nxt;

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   fill_inc;
  logic               mem_we;
  logic               mem_rd_en;
  logic [BYTE_W-1:0]  rd_data;
  lookup_t            lk;

  assign len      = eff_len(block_len_r);
  assign fill_inc = (fill_r == '1) ? fill_r : fill_r + LEN_W'(1);

  btc_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (ST_AW'(fill_r)),
    .wr_data (in_text_byte),
    .rd_en   (mem_rd_en),
    .rd_addr (lk.addr),
    .rd_data (rd_data)
  );

  // entries at or past fill_r read as spaces, so no clear pass is needed
  btc_keymap u_keymap (
    .perm_table   (perm_table_r),
    .scatter_mode (scatter_mode_r),
    .len          (len),
    .fill         (fill_r),
    .pos          (pos_r),
    .lk           (lk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r    <= RST_BLOCK_LEN;
      perm_table_r   <= RST_PERM_TABLE;
      scatter_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOCK_LEN:    block_len_r    <= cfg_wr_data[LEN_W-1:0];
        CFG_PERM_TABLE:   perm_table_r   <= cfg_wr_data[TABLE_W-1:0];
        CFG_SCATTER_MODE: scatter_mode_r <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_r      <= pad_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    pad_nxt       = pad_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    mem_we        = 1'b0;
    mem_rd_en     = 1'b0;

    // output word taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mem_we   = (int'(fill_r) < MAX_BLOCK);
          fill_nxt = fill_inc;
          if ((fill_inc >= len) || in_text_end) begin
            pos_nxt   = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_rd_en = 1'b1;
        pad_nxt   = lk.pad;
        last_nxt  = ((LEN_W'(pos_r) + LEN_W'(1)) == len);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pad_r ? PAD_BYTE : rd_data;
          out_end_nxt   = last_r;
          if (last_r) begin
            fill_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r + KEY_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_out_byte  = out_byte_r;
  assign out_block_end = out_end_r;

endmodule

// ===== rtl/btc_store.sv =====
module btc_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  btc_pkg::st_addr_t             wr_addr,
  input  logic [btc_pkg::BYTE_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  btc_pkg::st_addr_t             rd_addr,
  output logic [btc_pkg::BYTE_W-1:0]    rd_data
);
  import btc_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_BLOCK];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/btc_keymap.sv =====
module btc_keymap (
  input  logic [btc_pkg::TABLE_W-1:0] perm_table,
  input  logic                        scatter_mode,
  input  logic [btc_pkg::LEN_W-1:0]   len,
  input  logic [btc_pkg::LEN_W-1:0]   fill,
  input  btc_pkg::key_t               pos,
  output btc_pkg::lookup_t            lk
);
  import btc_pkg::*;

  key_t k;
  key_t src;
  logic found;

  always_comb begin
    k     = key_at(perm_table, pos);
    src   = '0;
    found = 1'b0;
    // scatter: highest source index landing on this position wins
    for (int j = 0; j < KEY_N; j++) begin
      if ((LEN_W'(j) < len) && (key_at(perm_table, KEY_W'(j)) == pos)) begin
        found = 1'b1;
        src   = KEY_W'(j);
      end
    end

    if (scatter_mode) begin
      lk.addr = ST_AW'(src);
      lk.pad  = !found || (LEN_W'(src) >= fill);
    end else begin
      lk.addr = ST_AW'(k);
      lk.pad  = (LEN_W'(k) >= len) || (LEN_W'(k) >= fill);
    end
  end

endmodule
